/* src/psev_pkg.sv */
// ----------------------------------------------------------------------------
// psev_pkg: shared types and constants for the postfix stack evaluator
// Token codes, status codes, state encodings and the request/response
// bundles between the sequencer and the shared arithmetic unit.
// ----------------------------------------------------------------------------
package psev_pkg;

    localparam int OP_W      = 4;
    localparam int LIT_W     = 32;
    localparam int VALUE_W   = 32;
    localparam int STATUS_W  = 3;
    localparam int M_TDATA_W = 40;   // value + status, padded to whole bytes

    typedef enum logic [OP_W-1:0] {
        OP_PUSH = 4'd0,
        OP_MUL  = 4'd1,
        OP_DIV  = 4'd2,
        OP_MOD  = 4'd3,
        OP_ADD  = 4'd4,
        OP_SUB  = 4'd5,
        OP_LT   = 4'd6,
        OP_LE   = 4'd7,
        OP_GT   = 4'd8,
        OP_GE   = 4'd9,
        OP_NE   = 4'd10,
        OP_EQ   = 4'd11,
        OP_NOT  = 4'd12,
        OP_AND  = 4'd13,
        OP_OR   = 4'd14
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 3'd0,
        STAT_UNDERFLOW = 3'd1,
        STAT_OVERFLOW  = 3'd2,
        STAT_DIV_ZERO  = 3'd3,
        STAT_EMPTY     = 3'd4,
        STAT_SATURATED = 3'd5
    } status_t;

    // token sequencer
    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_OPERAND,
        S_ALU,
        S_EMIT
    } fsm_state_t;

    // shared arithmetic unit
    typedef enum logic [2:0] {
        A_IDLE,
        A_MUL,
        A_DIV,
        A_FIN,
        A_DONE
    } alu_state_t;

    typedef struct packed {
        logic start;
        op_t  op;
    } alu_req_t;

    typedef struct packed {
        logic done;
        logic sat;
        logic div_zero;
    } alu_rsp_t;

    // operators that take two stack entries
    function automatic logic is_binary(input op_t op);
        logic [OP_W-1:0] code;
        code = op;
        return (code >= OP_MUL) && (code <= OP_OR) && (code != OP_NOT);
    endfunction

endpackage

/* src/psev_ram.sv */
// ----------------------------------------------------------------------------
// psev_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle. No reset on contents.
// ----------------------------------------------------------------------------
module psev_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* src/psev_alu.sv */
// ----------------------------------------------------------------------------
// psev_alu: shared arithmetic unit of the postfix stack evaluator
// One adder serves add/sub/compare, shift-add multiply,
// restoring divide/modulo, and the final sign/saturate step.
// ----------------------------------------------------------------------------
module psev_alu #(
    parameter int FRAC_BITS = 16
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  psev_pkg::alu_req_t      req,
    input  logic [32+FRAC_BITS-1:0] a,
    input  logic [32+FRAC_BITS-1:0] b,
    output psev_pkg::alu_rsp_t      rsp,
    output logic [32+FRAC_BITS-1:0] result
);

    localparam int VW = 32 + FRAC_BITS;    // value width
    localparam int DW = VW + FRAC_BITS;    // dividend / quotient width
    localparam int AW = VW + 2;            // adder width
    localparam int PW = 2 * VW;            // full product width
    localparam int CW = $clog2(DW + 1);

    localparam logic [CW-1:0] CNT_MUL  = CW'(VW);
    localparam logic [CW-1:0] CNT_DIV  = CW'(DW);
    localparam logic [CW-1:0] CNT_LAST = CW'(1);

    localparam logic [VW-1:0] ONE_FX  = VW'(1) << FRAC_BITS;
    localparam logic [VW-1:0] POS_MAX = {1'b0, {(VW-1){1'b1}}};
    localparam logic [VW-1:0] NEG_MAX = {1'b1, {(VW-1){1'b0}}};

    psev_pkg::alu_state_t state_reg, state_next;
    psev_pkg::op_t        op_reg, op_next;
    logic                 neg_reg, neg_next;
    logic [VW-1:0]        mcand_reg, mcand_next;   // multiplicand or divisor
    logic [VW:0]          hi_reg, hi_next;         // product high / remainder
    logic [DW-1:0]        lo_reg, lo_next;         // multiplier / dividend
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic [VW-1:0]        result_reg, result_next;
    logic                 sat_reg, sat_next;
    logic                 dz_reg, dz_next;

    logic [VW-1:0] mag_a, mag_b;
    logic          start_dz;
    logic [AW-1:0] add_x, add_y, add_sum;
    logic          add_sub;
    logic [VW:0]   rem_sh;
    logic          qbit;
    logic [PW-1:0] fin_mag;
    logic [VW-1:0] lim, fin_clip;
    logic          fin_sat;
    logic          eq_ab, lt_ab, ovf, a_nz, b_nz;
    logic [VW-1:0] simple_res;
    logic          simple_sat;

    assign mag_a = a[VW-1] ? (~a + VW'(1)) : a;
    assign mag_b = b[VW-1] ? (~b + VW'(1)) : b;

    // divide by zero, or modulo whose truncated divisor is zero
    always_comb begin
        if (req.op == psev_pkg::OP_MOD) begin
            start_dz = (mag_b[VW-1:FRAC_BITS] == '0);
        end else begin
            start_dz = (b == '0);
        end
    end

    // shared adder input selection
    assign rem_sh = {hi_reg[VW-1:0], lo_reg[DW-1]};

    always_comb begin
        add_x   = '0;
        add_y   = '0;
        add_sub = 1'b0;
        unique case (state_reg)
            psev_pkg::A_IDLE: begin
                add_x   = {{2{a[VW-1]}}, a};
                add_y   = {{2{b[VW-1]}}, b};
                add_sub = (req.op != psev_pkg::OP_ADD);
            end
            psev_pkg::A_MUL: begin
                add_x = AW'(hi_reg);
                add_y = lo_reg[0] ? AW'(mcand_reg) : '0;
            end
            psev_pkg::A_DIV: begin
                add_x   = AW'(rem_sh);
                add_y   = AW'(mcand_reg);
                add_sub = 1'b1;
            end
            psev_pkg::A_FIN: begin
                add_y   = AW'(fin_clip);
                add_sub = neg_reg;
            end
            default: begin
                add_x = '0;
            end
        endcase
    end

    assign add_sum = add_x + (add_sub ? ~add_y : add_y) + AW'(add_sub);
    assign qbit    = ~add_sum[AW-1];

    // magnitude to be signed and clipped at the end
    always_comb begin
        unique case (op_reg)
            psev_pkg::OP_MUL: fin_mag = {hi_reg[VW-1:0], lo_reg[DW-1:FRAC_BITS]} >> FRAC_BITS;
            psev_pkg::OP_MOD: fin_mag = PW'(hi_reg[VW-1:0]) << FRAC_BITS;
            default:          fin_mag = PW'(lo_reg);
        endcase
    end

    assign lim      = neg_reg ? NEG_MAX : POS_MAX;
    assign fin_sat  = (|fin_mag[PW-1:VW]) || (fin_mag[VW-1:0] > lim);
    assign fin_clip = fin_sat ? lim : fin_mag[VW-1:0];

    // combinational operators on the live operands
    assign eq_ab = (a == b);
    assign lt_ab = add_sum[AW-1];
    assign ovf   = (add_sum[VW] != add_sum[VW-1]);
    assign a_nz  = |a;
    assign b_nz  = |b;

    always_comb begin
        simple_sat = 1'b0;
        unique case (req.op)
            psev_pkg::OP_ADD,
            psev_pkg::OP_SUB: begin
                simple_res = ovf ? (add_sum[AW-1] ? NEG_MAX : POS_MAX) : add_sum[VW-1:0];
                simple_sat = ovf;
            end
            psev_pkg::OP_LT:  simple_res = lt_ab ? ONE_FX : '0;
            psev_pkg::OP_LE:  simple_res = (lt_ab || eq_ab) ? ONE_FX : '0;
            psev_pkg::OP_GT:  simple_res = (lt_ab || eq_ab) ? '0 : ONE_FX;
            psev_pkg::OP_GE:  simple_res = lt_ab ? '0 : ONE_FX;
            psev_pkg::OP_NE:  simple_res = eq_ab ? '0 : ONE_FX;
            psev_pkg::OP_EQ:  simple_res = eq_ab ? ONE_FX : '0;
            psev_pkg::OP_AND: simple_res = (a_nz && b_nz) ? ONE_FX : '0;
            psev_pkg::OP_OR:  simple_res = (a_nz || b_nz) ? ONE_FX : '0;
            default:          simple_res = '0;
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            psev_pkg::A_IDLE: begin
                if (req.start) begin
                    unique case (req.op)
                        psev_pkg::OP_MUL: state_next = psev_pkg::A_MUL;
                        psev_pkg::OP_DIV,
                        psev_pkg::OP_MOD: state_next = start_dz ? psev_pkg::A_DONE
                                                                : psev_pkg::A_DIV;
                        default:          state_next = psev_pkg::A_DONE;
                    endcase
                end
            end
            psev_pkg::A_MUL,
            psev_pkg::A_DIV: begin
                if (cnt_reg == CNT_LAST) begin
                    state_next = psev_pkg::A_FIN;
                end
            end
            psev_pkg::A_FIN:  state_next = psev_pkg::A_DONE;
            psev_pkg::A_DONE: state_next = psev_pkg::A_IDLE;
            default:          state_next = psev_pkg::A_IDLE;
        endcase
    end

    // datapath
    always_comb begin
        op_next     = op_reg;
        neg_next    = neg_reg;
        mcand_next  = mcand_reg;
        hi_next     = hi_reg;
        lo_next     = lo_reg;
        cnt_next    = cnt_reg;
        result_next = result_reg;
        sat_next    = sat_reg;
        dz_next     = dz_reg;
        unique case (state_reg)
            psev_pkg::A_IDLE: begin
                if (req.start) begin
                    op_next  = req.op;
                    sat_next = 1'b0;
                    dz_next  = 1'b0;
                    hi_next  = '0;
                    unique case (req.op)
                        psev_pkg::OP_MUL: begin
                            neg_next   = a[VW-1] ^ b[VW-1];
                            mcand_next = mag_a;
                            lo_next    = DW'(mag_b);
                            cnt_next   = CNT_MUL;
                        end
                        psev_pkg::OP_DIV: begin
                            neg_next    = a[VW-1] ^ b[VW-1];
                            mcand_next  = mag_b;
                            lo_next     = DW'(mag_a) << FRAC_BITS;
                            cnt_next    = CNT_DIV;
                            result_next = '0;
                            dz_next     = start_dz;
                        end
                        psev_pkg::OP_MOD: begin
                            neg_next    = a[VW-1];
                            mcand_next  = VW'(mag_b[VW-1:FRAC_BITS]);
                            lo_next     = DW'(mag_a[VW-1:FRAC_BITS]);
                            cnt_next    = CNT_DIV;
                            result_next = '0;
                            dz_next     = start_dz;
                        end
                        default: begin
                            result_next = simple_res;
                            sat_next    = simple_sat;
                        end
                    endcase
                end
            end
            psev_pkg::A_MUL: begin
                hi_next  = add_sum[VW+1:1];
                lo_next  = {add_sum[0], lo_reg[DW-1:1]};
                cnt_next = cnt_reg - CNT_LAST;
            end
            psev_pkg::A_DIV: begin
                hi_next  = qbit ? add_sum[VW:0] : rem_sh;
                lo_next  = {lo_reg[DW-2:0], qbit};
                cnt_next = cnt_reg - CNT_LAST;
            end
            psev_pkg::A_FIN: begin
                result_next = add_sum[VW-1:0];
                sat_next    = fin_sat;
            end
            default: begin
                result_next = result_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= psev_pkg::A_IDLE;
        end else begin
            state_reg <= state_next;
        end
        op_reg     <= op_next;
        neg_reg    <= neg_next;
        mcand_reg  <= mcand_next;
        hi_reg     <= hi_next;
        lo_reg     <= lo_next;
        cnt_reg    <= cnt_next;
        result_reg <= result_next;
        sat_reg    <= sat_next;
        dz_reg     <= dz_next;
    end

    assign rsp.done     = (state_reg == psev_pkg::A_DONE);
    assign rsp.sat      = sat_reg;
    assign rsp.div_zero = dz_reg;
    assign result       = result_reg;

endmodule

/* src/postfix_stack_evaluator_unit.sv */
// ----------------------------------------------------------------------------
// postfix_stack_evaluator_unit: postfix expression evaluator on a value stack
// Tokens come in on the s_ channel: s_tuser carries the operator code,
// s_tdata the literal pushed by a push token, s_tlast marks the final token.
// Values on the stack are signed fixed point, 32 integer and FRAC_BITS
// fraction bits. After the final token one word goes out on the m_ channel:
// the top of stack truncated toward zero plus the first error seen in the
// expression; the stack and status are then cleared for the next expression.
// Token handling, by the path each token takes:
//   push, not, unused code, underflow/overflow : sequencer only
//   add, sub, compares, and, or, div/mod by 0  : shared unit, no iteration
//   mul (bit-serial shift-add)                 : shared unit, iterative
//   div, mod (restoring, one quotient bit/cyc) : shared unit, iterative
// After the final token the result word is loaded in the emit state.
// s_tready is high only while waiting for a token. The result sits in an
// output register, so the next expression may start while it waits; a
// further result waits for that register to empty when m_tready is low.
// Reset (aresetn low, synchronous) empties the stack and clears the status.
// ----------------------------------------------------------------------------
module postfix_stack_evaluator_unit #(
    parameter int STACK_DEPTH = 16,
    parameter int FRAC_BITS   = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // token input
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [psev_pkg::LIT_W-1:0]           s_tdata,   // [31:0] literal
    input  logic [psev_pkg::OP_W-1:0]            s_tuser,   // [3:0] op
    input  logic                                 s_tlast,   // final token
    // result output
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [psev_pkg::M_TDATA_W-1:0]       m_tdata    // [31:0] value,
                                                            // [34:32] status,
                                                            // [39:35] zero
);

    localparam int VW     = 32 + FRAC_BITS;
    localparam int ADDR_W = $clog2(STACK_DEPTH);
    localparam int SP_W   = $clog2(STACK_DEPTH + 1);

    localparam logic [SP_W-1:0] SP_FULL = SP_W'(STACK_DEPTH);
    localparam logic [SP_W-1:0] SP_ONE  = SP_W'(1);
    localparam logic [SP_W-1:0] SP_TWO  = SP_W'(2);
    localparam logic [VW-1:0]   ONE_FX  = VW'(1) << FRAC_BITS;

    psev_pkg::fsm_state_t          state_reg, state_next;
    psev_pkg::op_t                 op_reg, op_next;
    logic [psev_pkg::LIT_W-1:0]    lit_reg, lit_next;
    logic                          last_reg, last_next;
    logic [SP_W-1:0]               sp_reg, sp_next;
    logic [VW-1:0]                 tos_reg, tos_next;     // mirror of top entry
    psev_pkg::status_t             err_reg, err_next;     // first error, sticky
    psev_pkg::status_t             note_code;
    logic                          clear_err;
    logic                          m_tvalid_reg, m_tvalid_next;
    logic [psev_pkg::VALUE_W-1:0]  m_value_reg, m_value_next;
    psev_pkg::status_t             m_status_reg, m_status_next;

    logic                          accept;
    logic                          out_free;
    logic                          is_bin;
    logic                          full, empty, below_two;
    logic [VW-1:0]                 lit_fx;
    logic [VW-1:0]                 tos_mag;
    logic [psev_pkg::VALUE_W-1:0]  tos_int, emit_value;
    psev_pkg::status_t             emit_status;

    logic                          ram_we;
    logic [ADDR_W-1:0]             ram_waddr, ram_raddr;
    logic [SP_W-1:0]               sp_m1, sp_m2;
    logic [VW-1:0]                 ram_rdata;

    psev_pkg::alu_req_t            alu_req;
    psev_pkg::alu_rsp_t            alu_rsp;
    logic [VW-1:0]                 alu_result;

    // value stack storage
    psev_ram #(
        .WIDTH (VW),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (tos_next),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // shared arithmetic unit
    psev_alu #(
        .FRAC_BITS (FRAC_BITS)
    ) u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (alu_req),
        .a       (ram_rdata),     // second entry from the top
        .b       (tos_reg),       // top entry
        .rsp     (alu_rsp),
        .result  (alu_result)
    );

    assign accept    = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign is_bin    = psev_pkg::is_binary(op_reg);
    assign full      = (sp_reg >= SP_FULL);
    assign empty     = (sp_reg == '0);
    assign below_two = (sp_reg < SP_TWO);
    assign sp_m1     = sp_reg - SP_ONE;
    assign sp_m2     = sp_reg - SP_TWO;

    // literal as fixed point: integer bits on top, fraction zero
    assign lit_fx = VW'(lit_reg) << FRAC_BITS;

    // top of stack truncated toward zero
    assign tos_mag     = tos_reg[VW-1] ? (~tos_reg + VW'(1)) : tos_reg;
    assign tos_int     = tos_mag[VW-1:FRAC_BITS];
    assign emit_value  = empty ? '0 : (tos_reg[VW-1] ? (~tos_int + 32'd1) : tos_int);
    assign emit_status = (empty && (err_reg == psev_pkg::STAT_OK)) ? psev_pkg::STAT_EMPTY
                                                                     : err_reg;

    // sequencer: next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            psev_pkg::S_IDLE: begin
                if (accept) begin
                    state_next = psev_pkg::S_DECODE;
                end
            end
            psev_pkg::S_DECODE: begin
                if (is_bin && !below_two) begin
                    state_next = psev_pkg::S_OPERAND;
                end else begin
                    state_next = last_reg ? psev_pkg::S_EMIT : psev_pkg::S_IDLE;
                end
            end
            psev_pkg::S_OPERAND: state_next = psev_pkg::S_ALU;
            psev_pkg::S_ALU: begin
                if (alu_rsp.done) begin
                    state_next = last_reg ? psev_pkg::S_EMIT : psev_pkg::S_IDLE;
                end
            end
            psev_pkg::S_EMIT: begin
                if (out_free) begin
                    state_next = psev_pkg::S_IDLE;
                end
            end
            default: state_next = psev_pkg::S_IDLE;
        endcase
    end

    // sequencer: control outputs
    always_comb begin
        s_tready      = (state_reg == psev_pkg::S_IDLE);
        alu_req.start = (state_reg == psev_pkg::S_OPERAND);
        alu_req.op    = op_reg;
        ram_raddr     = sp_m2[ADDR_W-1:0];   // second entry, read during decode
        ram_we        = 1'b0;
        ram_waddr     = sp_m1[ADDR_W-1:0];
        unique case (state_reg)
            psev_pkg::S_DECODE: begin
                if (op_reg == psev_pkg::OP_PUSH) begin
                    ram_we    = !full;
                    ram_waddr = sp_reg[ADDR_W-1:0];
                end else if (op_reg == psev_pkg::OP_NOT) begin
                    ram_we    = !empty;
                end
            end
            psev_pkg::S_ALU: begin
                ram_we    = alu_rsp.done;
                ram_waddr = sp_m2[ADDR_W-1:0];
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    // stack pointer, top entry, status and result word
    always_comb begin
        op_next       = op_reg;
        lit_next      = lit_reg;
        last_next     = last_reg;
        sp_next       = sp_reg;
        tos_next      = tos_reg;
        note_code     = psev_pkg::STAT_OK;
        clear_err     = 1'b0;
        m_value_next  = m_value_reg;
        m_status_next = m_status_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        unique case (state_reg)
            psev_pkg::S_IDLE: begin
                if (accept) begin
                    op_next   = psev_pkg::op_t'(s_tuser);
                    lit_next  = s_tdata;
                    last_next = s_tlast;
                end
            end
            psev_pkg::S_DECODE: begin
                if (op_reg == psev_pkg::OP_PUSH) begin
                    if (full) begin
                        note_code = psev_pkg::STAT_OVERFLOW;
                    end else begin
                        sp_next  = sp_reg + SP_ONE;
                        tos_next = lit_fx;
                    end
                end else if (op_reg == psev_pkg::OP_NOT) begin
                    if (empty) begin
                        note_code = psev_pkg::STAT_UNDERFLOW;
                    end else begin
                        tos_next = (tos_reg == '0) ? ONE_FX : '0;
                    end
                end else if (is_bin && below_two) begin
                    note_code = psev_pkg::STAT_UNDERFLOW;
                end
            end
            psev_pkg::S_ALU: begin
                if (alu_rsp.done) begin
                    sp_next  = sp_m1;
                    tos_next = alu_result;
                    if (alu_rsp.div_zero) begin
                        note_code = psev_pkg::STAT_DIV_ZERO;
                    end else if (alu_rsp.sat) begin
                        note_code = psev_pkg::STAT_SATURATED;
                    end
                end
            end
            psev_pkg::S_EMIT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_value_next  = emit_value;
                    m_status_next = emit_status;
                    sp_next       = '0;
                    clear_err     = 1'b1;
                end
            end
            default: begin
                note_code = psev_pkg::STAT_OK;
            end
        endcase

        if (clear_err) begin
            err_next = psev_pkg::STAT_OK;
        end else if (err_reg == psev_pkg::STAT_OK) begin
            err_next = note_code;
        end else begin
            err_next = err_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= psev_pkg::S_IDLE;
            sp_reg       <= '0;
            err_reg      <= psev_pkg::STAT_OK;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            sp_reg       <= sp_next;
            err_reg      <= err_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        op_reg       <= op_next;
        lit_reg      <= lit_next;
        last_reg     <= last_next;
        tos_reg      <= tos_next;
        m_value_reg  <= m_value_next;
        m_status_reg <= m_status_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'b0, m_status_reg, m_value_reg};

endmodule
